// File: rtl/core/pll_divider_search_unit_defines.svh
// Assertion macros shared by the divider search checker.
`ifndef PLL_DIVIDER_SEARCH_UNIT_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: rtl/core/pds_pkg.sv
// Types, constants and the per-reference-divider table of the divider search.
`default_nettype none
package pds_pkg;

  localparam int unsigned PIX_W  = 20;
  localparam int unsigned POST_W = 6;
  localparam int unsigned LOOP_W = 8;
  localparam int unsigned REF_W  = 3;
  localparam int unsigned VCO_W  = 22;  // VCO stays at or below 3200000
  localparam int unsigned REM_W  = 3;
  localparam int unsigned TOL    = 1000;

  localparam logic [REF_W-1:0] REF_FIRST = 3'd3;
  localparam logic [REF_W-1:0] REF_LAST  = 3'd5;

  typedef struct packed {
    logic start;  // load a new pixel clock, first candidate
    logic step;   // advance to the next candidate
    logic load;   // capture the result register
  } cmd_t;

  typedef struct packed {
    logic match;  // current candidate is within tolerance
    logic last;   // current candidate is the final one
  } status_t;

  // Loop count span and VCO stepping per reference divider. The span is
  // 12*ref..32*ref clipped to 24..160; the VCO at the span start is exact.
  typedef struct packed {
    logic [LOOP_W-1:0] loop_start;
    logic [LOOP_W-1:0] loop_stop;
    logic [VCO_W-1:0]  vco_start;
    logic [VCO_W-1:0]  vco_quot;   // 100000 / ref
    logic [REM_W-1:0]  vco_rem;    // 100000 % ref
  } ref_info_t;

  function automatic ref_info_t ref_info(input logic [REF_W-1:0] ref_div);
    ref_info_t info;
    case (ref_div)
      3'd3:    info = '{8'd36, 8'd96,  22'd1200000, 22'd33333, 3'd1};
      3'd4:    info = '{8'd48, 8'd128, 22'd1200000, 22'd25000, 3'd0};
      3'd5:    info = '{8'd60, 8'd160, 22'd1200000, 22'd20000, 3'd0};
      default: info = '{8'd36, 8'd96,  22'd1200000, 22'd33333, 3'd1};
    endcase
    return info;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pds_in_if.sv
// Input channel: requested pixel clock.
`default_nettype none
interface pds_in_if;
  logic                        valid;
  logic                        ready;
  logic [pds_pkg::PIX_W-1:0]   pix_clock_khz;

  modport source (output valid, output pix_clock_khz, input ready);
  modport sink   (input valid, input pix_clock_khz, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pds_out_if.sv
// Output channel: chosen PLL divider triple.
`default_nettype none
interface pds_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [pds_pkg::POST_W-1:0]  post_divider;
  logic [pds_pkg::LOOP_W-1:0]  loop_count;
  logic [pds_pkg::REF_W-1:0]   ref_divider;

  modport source (output valid, output found, output post_divider,
                  output loop_count, output ref_divider, input ready);
  modport sink   (input valid, input found, input post_divider,
                  input loop_count, input ref_divider, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pds_ctrl.sv
// Search controller: handshakes, search sequencing, result valid.
`default_nettype none
module pds_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire pds_pkg::status_t  status_i,
  output pds_pkg::cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   done;

  assign out_free = !out_valid_q || out_ready_i;
  assign done     = status_i.match || status_i.last;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!done) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/pds_dp.sv
// Search datapath: candidate counters, incremental VCO, match test, result.
`default_nettype none
module pds_dp #(
  parameter int unsigned POST_DIV_LIMIT = 64
) (
  input  wire logic                          clk_i,
  input  wire pds_pkg::cmd_t                 cmd_i,
  input  wire logic [pds_pkg::PIX_W-1:0]     pix_clock_khz_i,
  output pds_pkg::status_t                   status_o,
  output logic                               found_o,
  output logic [pds_pkg::POST_W-1:0]         post_divider_o,
  output logic [pds_pkg::LOOP_W-1:0]         loop_count_o,
  output logic [pds_pkg::REF_W-1:0]          ref_divider_o
);

  localparam int unsigned PW = $clog2(POST_DIV_LIMIT);
  localparam int unsigned WW = pds_pkg::PIX_W + PW;
  localparam int unsigned DW = ((WW > pds_pkg::VCO_W) ? WW : pds_pkg::VCO_W) + 1;
  localparam logic [PW-1:0] POST_LAST = PW'(POST_DIV_LIMIT - 1);

  logic [pds_pkg::PIX_W-1:0]  clk_q;
  logic [PW-1:0]              post_q;
  logic [WW-1:0]              want_q;
  logic [pds_pkg::REF_W-1:0]  ref_q;
  logic [pds_pkg::LOOP_W-1:0] loop_q;
  logic [pds_pkg::VCO_W-1:0]  vco_q;
  logic [pds_pkg::REM_W-1:0]  rem_q;

  pds_pkg::ref_info_t         cur_info, nxt_info, first_info;
  logic [pds_pkg::REF_W-1:0]  ref_next;
  logic [pds_pkg::REM_W-1:0]  rem_sum;
  logic                       rem_wrap;
  logic signed [DW-1:0]       diff;
  logic                       loop_end, ref_end;
  logic [PW+pds_pkg::POST_W-1:0] post_ext;

  assign cur_info   = pds_pkg::ref_info(ref_q);
  assign ref_next   = ref_end ? pds_pkg::REF_FIRST : ref_q + 3'd1;
  assign nxt_info   = pds_pkg::ref_info(ref_next);
  assign first_info = pds_pkg::ref_info(pds_pkg::REF_FIRST);

  assign loop_end = (loop_q == cur_info.loop_stop);
  assign ref_end  = (ref_q == pds_pkg::REF_LAST);

  assign rem_sum  = rem_q + cur_info.vco_rem;
  assign rem_wrap = (rem_sum >= ref_q);

  assign diff = $signed(DW'(want_q)) - $signed(DW'(vco_q));
  assign status_o.match = (diff < $signed(DW'(pds_pkg::TOL)))
                       && (diff > -$signed(DW'(pds_pkg::TOL)));
  assign status_o.last  = loop_end && ref_end && (post_q == POST_LAST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      clk_q  <= pix_clock_khz_i;
      post_q <= PW'(1);
      want_q <= WW'(pix_clock_khz_i);
      ref_q  <= pds_pkg::REF_FIRST;
      loop_q <= first_info.loop_start;
      vco_q  <= first_info.vco_start;
      rem_q  <= '0;
    end else if (cmd_i.step) begin
      if (loop_end) begin
        // next reference divider (and post divider after the last one)
        ref_q  <= ref_next;
        loop_q <= nxt_info.loop_start;
        vco_q  <= nxt_info.vco_start;
        rem_q  <= '0;
        if (ref_end) begin
          post_q <= post_q + PW'(1);
          want_q <= want_q + WW'(clk_q);
        end
      end else begin
        loop_q <= loop_q + 8'd1;
        vco_q  <= vco_q + cur_info.vco_quot + pds_pkg::VCO_W'(rem_wrap);
        rem_q  <= rem_wrap ? rem_sum - ref_q : rem_sum;
      end
    end
  end

  assign post_ext = {pds_pkg::POST_W'(0), post_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      found_o        <= status_o.match;
      post_divider_o <= status_o.match ? post_ext[pds_pkg::POST_W-1:0] : '0;
      loop_count_o   <= status_o.match ? loop_q : '0;
      ref_divider_o  <= status_o.match ? ref_q : '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pll_divider_search_unit.sv
// Top level of the PLL divider search unit.
// Usage:
//   in_i  (sink)   : one transfer carries pix_clock_khz, the wanted pixel
//                    clock in kHz. ready is high only while the unit is idle.
//   out_o (source) : one transfer per request: found plus the divider
//                    triple (post_divider, loop_count, ref_divider), all
//                    zero when nothing fits.
// Search: post divider 1..POST_DIV_LIMIT-1, then ref divider 3..5, then
//   loop count over 12*ref..32*ref, one candidate per cycle. The VCO is
//   stepped by 100000/ref with a remainder carry, so no divider is needed.
// Result: the result register loads at the end of the cycle that tests
//   the hit (or the final candidate). 243 candidates per post divider,
//   15309 at most with the default limit. The unit then returns to idle
//   before it takes the next request. One request is in flight at a time.
// Receiver stall: the result waits in the output register; a new request
//   can be taken meanwhile, and its search holds on its final candidate
//   until the register frees up.
// Reset: asynchronous, active low; clears the controller and result valid.
`default_nettype none
module pll_divider_search_unit #(
  parameter int unsigned POST_DIV_LIMIT = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pds_in_if.sink     in_i,
  pds_out_if.source  out_o
);

  pds_pkg::cmd_t     cmd;
  pds_pkg::status_t  status;

  pds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pds_dp #(
    .POST_DIV_LIMIT (POST_DIV_LIMIT)
  ) u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .pix_clock_khz_i (in_i.pix_clock_khz),
    .status_o        (status),
    .found_o         (out_o.found),
    .post_divider_o  (out_o.post_divider),
    .loop_count_o    (out_o.loop_count),
    .ref_divider_o   (out_o.ref_divider)
  );

endmodule
`default_nettype wire

// File: rtl/core/pds_checker.sv
// Port-level checks for the PLL divider search unit, bound to the top level.
`default_nettype none
`include "pll_divider_search_unit_defines.svh"
module pds_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic                         found_i,
  input wire logic [pds_pkg::POST_W-1:0]   post_divider_i,
  input wire logic [pds_pkg::LOOP_W-1:0]   loop_count_i,
  input wire logic [pds_pkg::REF_W-1:0]    ref_divider_i
);

  `PDS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `PDS_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_i, !in_ready_i)
  `PDS_ASSERT_NOW(a_miss_zero, out_valid_i && !found_i,
                  post_divider_i == '0 && loop_count_i == '0 && ref_divider_i == '0)
  `PDS_ASSERT_NOW(a_hit_range, out_valid_i && found_i,
                  (ref_divider_i == 3'd3 || ref_divider_i == 3'd4 || ref_divider_i == 3'd5)
                  && loop_count_i >= 8'd36 && loop_count_i <= 8'd160)

endmodule

bind pll_divider_search_unit pds_checker u_pds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .found_i        (out_o.found),
  .post_divider_i (out_o.post_divider),
  .loop_count_i   (out_o.loop_count),
  .ref_divider_i  (out_o.ref_divider)
);
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the PLL divider search unit.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Search bounds the predictor walks. These mirror the unit's documented
  // behavior and are not taken from the RTL.
  localparam int unsigned POST_LIMIT   = 64;
  localparam longint      VCO_UNIT_KHZ = 100000;
  localparam longint      TOL_KHZ      = 1000;
  localparam int          REF_LO       = 3;
  localparam int          REF_HI       = 5;
  localparam int          LOOP_LO      = 24;
  localparam int          LOOP_HI      = 160;
  localparam int          LOOP_PER_REF_MIN = 12;
  localparam int          LOOP_PER_REF_MAX = 32;

  localparam logic [pds_pkg::PIX_W-1:0] PIX_MAX = '1;

  // Covers the worst search, the longest receiver hold and the longest
  // sender gap, then leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 60000;
  // Nothing is in flight once the last result is back; this only gives a
  // stray extra result time to show up.
  localparam int unsigned DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic                       found;
    logic [pds_pkg::POST_W-1:0] post_divider;
    logic [pds_pkg::LOOP_W-1:0] loop_count;
    logic [pds_pkg::REF_W-1:0]  ref_divider;
  } dividers_t;

  // How the result side accepts transfers.
  typedef enum logic [1:0] {
    SINK_OPEN,     // ready every cycle
    SINK_PATTERN,  // ready follows a rotating 16-bit pattern
    SINK_HOLD      // ready drops for a long random stretch after each transfer
  } sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pds_in_if  req_if ();
  pds_out_if rsp_if ();

  pll_divider_search_unit #(
    .POST_DIV_LIMIT(POST_LIMIT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  dividers_t   pending_q[$];   // expected triples, oldest first
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  // Sender burst control.
  int unsigned burst_left = 0;
  int unsigned gap_max    = 0;

  // Receiver stall control.
  sink_mode_e  sink_mode    = SINK_OPEN;
  logic [15:0] sink_pattern = '1;
  logic [3:0]  sink_phase   = '0;
  int unsigned hold_left    = 0;

  // Walk post, reference and loop in search order and return the first
  // triple whose VCO lies strictly within the tolerance of clock*post.
  // Loop counts outside 12*ref..32*ref are skipped. The VCO is truncated.
  function automatic dividers_t predict_dividers(input logic [pds_pkg::PIX_W-1:0] khz);
    dividers_t pick;
    longint    want;
    longint    vco;
    longint    diff;
    pick = '0;
    for (int post = 1; post < POST_LIMIT; post++) begin
      want = longint'(khz) * post;
      for (int rd = REF_LO; rd <= REF_HI; rd++) begin
        for (int lc = LOOP_LO; lc <= LOOP_HI; lc++) begin
          if (lc < LOOP_PER_REF_MIN * rd || lc > LOOP_PER_REF_MAX * rd) continue;
          vco  = (VCO_UNIT_KHZ * lc) / rd;
          diff = (want > vco) ? want - vco : vco - want;
          if (diff < TOL_KHZ) begin
            pick.found        = 1'b1;
            // Masked to the port widths; only matters if the limit grows past 64.
            pick.post_divider = pds_pkg::POST_W'(post);
            pick.loop_count   = pds_pkg::LOOP_W'(lc);
            pick.ref_divider  = pds_pkg::REF_W'(rd);
            return pick;
          end
        end
      end
    end
    return pick;
  endfunction

  // Build a clock near a real grid point: pick ref and loop, add an offset
  // of up to the tolerance, then divide by a post divider. Mostly small post
  // dividers so searches stay short; now and then a deep one.
  function automatic logic [pds_pkg::PIX_W-1:0] matching_clock();
    int     rd;
    int     lc;
    int     post;
    longint target;
    rd     = $urandom_range(REF_HI, REF_LO);
    lc     = $urandom_range(LOOP_PER_REF_MAX * rd > LOOP_HI ? LOOP_HI : LOOP_PER_REF_MAX * rd,
                            LOOP_PER_REF_MIN * rd < LOOP_LO ? LOOP_LO : LOOP_PER_REF_MIN * rd);
    target = (VCO_UNIT_KHZ * lc) / rd + longint'($urandom_range(1998, 0)) - 999;
    post   = ($urandom_range(4, 0) == 0) ? $urandom_range(POST_LIMIT - 1, 2)
                                         : $urandom_range(8, 2);
    // Keep the clock within 20 bits.
    while (target / post > longint'(PIX_MAX)) post++;
    return pds_pkg::PIX_W'(target / post);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Drive one request and wait for its transfer. valid stays high across a
  // burst; a gap lowers it for a random number of cycles first.
  task automatic send_clock(input logic [pds_pkg::PIX_W-1:0] khz);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(gap_max, 0);
      burst_left = $urandom_range(8, 1);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_if.valid         <= 1'b1;
    req_if.pix_clock_khz <= khz;
    do @(posedge clk_i); while (!req_if.ready);
    pending_q.push_back(predict_dividers(khz));
    burst_left--;
  endtask

  // Result side. ready is driven at the clock edge; in hold mode a transfer
  // starts a long stall so the next search finishes into a busy register.
  always @(posedge clk_i) begin
    sink_phase <= sink_phase + 1'b1;
    if (rsp_if.valid && rsp_if.ready && sink_mode == SINK_HOLD) begin
      hold_left    <= $urandom_range(1500, 100);
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (sink_mode == SINK_PATTERN) begin
      rsp_if.ready <= sink_pattern[sink_phase];
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    dividers_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: found=%0b post=%0d loop=%0d ref=%0d",
                                  rsp_if.found, rsp_if.post_divider,
                                  rsp_if.loop_count, rsp_if.ref_divider));
      end else begin
        want = pending_q.pop_front();
        if (rsp_if.found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", rsp_if.found, want.found));
        if (rsp_if.post_divider !== want.post_divider)
          report_mismatch($sformatf("post_divider %0d, want %0d",
                                    rsp_if.post_divider, want.post_divider));
        if (rsp_if.loop_count !== want.loop_count)
          report_mismatch($sformatf("loop_count %0d, want %0d",
                                    rsp_if.loop_count, want.loop_count));
        if (rsp_if.ref_divider !== want.ref_divider)
          report_mismatch($sformatf("ref_divider %0d, want %0d",
                                    rsp_if.ref_divider, want.ref_divider));
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Corner clocks: zero and tiny clocks (no match), the edge of reach at the
  // deepest post divider, the tolerance edge (999 passes, 1000 fails),
  // first hits on ref 4 and ref 5, exact grid hits, all-ones and
  // alternating bit patterns, and the top bit alone.
  task automatic test_corner_clocks();
    logic [pds_pkg::PIX_W-1:0] corner [15] = '{
      20'd0, 20'd1, 20'd19031, 20'd19032, 20'd19048, PIX_MAX,
      20'd399667, 20'd599500, 20'd612500, 20'd610000, 20'd600000,
      20'd533333, 20'h55555, 20'hAAAAA, 20'h80000
    };
    gap_max      = 3;
    sink_mode    = SINK_PATTERN;
    sink_pattern = 16'b1011_0111_1110_1101;
    foreach (corner[i]) send_clock(corner[i]);
  endtask

  // Clocks built near grid points with random sender gaps between bursts,
  // and a random receiver pattern.
  task automatic test_matched_searches(input int count);
    gap_max      = 600;
    sink_mode    = SINK_PATTERN;
    sink_pattern = 16'($urandom_range(16'hFFFF, 1));
    repeat (count) send_clock(matching_clock());
  endtask

  // No idling on either side: requests wait on ready alone.
  task automatic test_back_to_back(input int count);
    gap_max   = 0;
    sink_mode = SINK_OPEN;
    repeat (count) send_clock(matching_clock());
  endtask

  // Long receiver stalls: the next search must hold its final candidate
  // until the result register is drained.
  task automatic test_result_hold(input int count);
    gap_max   = 0;
    sink_mode = SINK_HOLD;
    repeat (count) send_clock(matching_clock());
  endtask

  // Uniform clocks over the whole 20-bit range; includes misses.
  task automatic test_uniform_clocks(input int count);
    gap_max      = 40;
    sink_mode    = SINK_PATTERN;
    sink_pattern = 16'($urandom_range(16'hFFFF, 1));
    repeat (count) send_clock($urandom_range(PIX_MAX, 0));
  endtask

  initial begin
    req_if.valid         = 1'b0;
    req_if.pix_clock_khz = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_clocks();
    test_matched_searches(35);
    test_back_to_back(20);
    test_result_hold(15);
    test_uniform_clocks(30);

    req_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
